[hdl/lpct_pkg.sv]
package lpct_pkg;

    localparam int NW = 25;

    typedef struct packed {
        logic          operation;
        logic [NW-1:0] query_value;
    } lpct_in_t;

    typedef struct packed {
        logic [NW-1:0] prime_count;
        logic          count_valid;
    } lpct_out_t;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Divider request and response between top level and lpct_div
    typedef struct packed {
        logic          start;
        logic [NW-1:0] dividend;
        logic [NW-1:0] divisor;
    } lpct_div_req_t;

    typedef struct packed {
        logic          done;
        logic [NW-1:0] quotient;
    } lpct_div_rsp_t;

endpackage

[hdl/lucy_prime_count_table_unit.sv]
// Prime counting table (Lucy sieve). A build beat latches n from cfg_reg,
// takes r = isqrt(n) and fills a count memory of r + n/r - 1 entries, then
// runs the sieve update for every prime p <= r; a query beat returns pi(v) for
// v below 2 or a key of the table. All counts live in one memory with one read
// and one write port; every head key and every quotient comes from a shared
// serial divider. A query for v up to n/r takes one division and a read, a
// larger v two divisions; v below 2, above n or before a build answers through
// the pending and output registers without a division. A build runs a bitwise
// square root and one division, fills each head entry with one division and
// each tail entry without one, reads S(p-1) and S(p) for the prime test per p,
// and spends one division (v/p) per updated key when key and v/p sit in the
// tail, plus one division of n for each of them that does not. There is no
// clearing pass. The result waits in an output register while the next beat
// is taken.
module lucy_prime_count_table_unit
    import lpct_pkg::*;
#(
    parameter int MAX_ROOT = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [NW-1:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  lpct_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output lpct_out_t out_data
);

    localparam int DEPTH = 2 * MAX_ROOT + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = 32;

    // states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SQRT   = 5'd1;
    localparam logic [4:0] S_LEN    = 5'd2;
    localparam logic [4:0] S_FKEY   = 5'd3;
    localparam logic [4:0] S_FWR    = 5'd4;
    localparam logic [4:0] S_PRD1   = 5'd5;
    localparam logic [4:0] S_PRD2   = 5'd6;
    localparam logic [4:0] S_PCHK   = 5'd7;
    localparam logic [4:0] S_UKEY   = 5'd8;
    localparam logic [4:0] S_UDIV   = 5'd9;
    localparam logic [4:0] S_URD1   = 5'd10;
    localparam logic [4:0] S_URD2   = 5'd11;
    localparam logic [4:0] S_UWR    = 5'd12;
    localparam logic [4:0] S_QDIV1  = 5'd13;
    localparam logic [4:0] S_QDIV2  = 5'd14;
    localparam logic [4:0] S_QRD    = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd17;
    localparam logic [4:0] S_WAIT   = 5'd18;
    localparam logic [4:0] S_SLOT   = 5'd19;

    logic [4:0]    state_reg, state_next;
    logic [NW-1:0] cfg_reg;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] r_reg, r_next;
    logic [NW-1:0] top_reg, top_next;     // n / r
    logic [NW:0]   len_reg, len_next;
    logic          built_reg, built_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] p_reg, p_next;
    logic [CW-1:0] below_reg, below_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [NW-1:0] v_reg, v_next;
    logic [NW-1:0] q_reg, q_next;
    logic [3:0]    sub_reg, sub_next;     // sub-step for shared divider users
    // square root
    logic [NW+1:0] sq_rem_reg, sq_rem_next;
    logic [NW+1:0] sq_res_reg, sq_res_next;
    logic [NW+1:0] sq_bit_reg, sq_bit_next;
    // output
    logic          ov_reg, ov_next;
    lpct_out_t     od_reg, od_next;
    logic          pend_reg, pend_next;
    lpct_out_t     pd_reg, pd_next;

    lpct_div_req_t dreq;
    lpct_div_rsp_t drsp;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] wdata, rdata;
    logic          in_acc;
    logic          out_free;

    lpct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    lpct_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // slot of a value at or below the tail top
    function automatic logic [AW-1:0] tail_slot(input logic [NW:0] len,
                                                input logic [NW-1:0] v);
        logic [NW:0] d;
        d = len - {1'b0, v};
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] head_slot(input logic [NW-1:0] q);
        logic [NW-1:0] d;
        d = q - 1'b1;
        return d[AW-1:0];
    endfunction

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || pend_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= NW'(1000000);
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // sequencer
    always_comb
    begin
        logic [NW+1:0] sum;
        logic [NW:0]   keyv;
        logic [2*NW-1:0] psq;
        state_next  = state_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        top_next    = top_reg;
        len_next    = len_reg;
        built_next  = built_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        below_next  = below_reg;
        cur_next    = cur_reg;
        v_next      = v_reg;
        q_next      = q_reg;
        sub_next    = sub_reg;
        sq_rem_next = sq_rem_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        pend_next   = pend_reg;
        pd_next     = pd_reg;
        dreq        = '0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;
        sum         = sq_res_reg + sq_bit_reg;
        keyv        = '0;
        psq         = p_reg * p_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_data.operation == OP_BUILD)
                    begin
                        n_next      = cfg_reg;
                        built_next  = 1'b0;
                        len_next    = '0;
                        r_next      = '0;
                        sq_rem_next = {2'b00, cfg_reg};
                        sq_res_next = '0;
                        sq_bit_next = (NW+2)'(1) << (NW - 1);
                        state_next  = S_SQRT;
                    end
                    else if (!built_reg)
                    begin
                        pd_next   = '0;
                        pend_next = 1'b1;
                    end
                    else if (in_data.query_value < NW'(2))
                    begin
                        pd_next   = '{prime_count: '0, count_valid: 1'b1};
                        pend_next = 1'b1;
                    end
                    else if (in_data.query_value > n_reg)
                    begin
                        pd_next   = '0;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        v_next     = in_data.query_value;
                        dreq       = '{start: 1'b1, dividend: n_reg,
                                       divisor: in_data.query_value};
                        state_next = S_QDIV1;
                    end
                end
            end
            // bitwise integer square root, one result bit a cycle
            S_SQRT:
            begin
                if (sq_bit_reg == '0)
                begin
                    if (n_reg == '0 || sq_res_reg > (NW+2)'(MAX_ROOT))
                    begin
                        pd_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next     = sq_res_reg[NW-1:0];
                        dreq       = '{start: 1'b1, dividend: n_reg,
                                       divisor: sq_res_reg[NW-1:0]};
                        state_next = S_LEN;
                    end
                end
                else
                begin
                    if (sq_rem_reg >= sum)
                    begin
                        sq_rem_next = sq_rem_reg - sum;
                        sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_next = sq_res_reg >> 1;
                    end
                    sq_bit_next = sq_bit_reg >> 2;
                end
            end
            S_LEN:
            begin
                if (drsp.done)
                begin
                    top_next   = drsp.quotient;
                    len_next   = {1'b0, r_reg} + {1'b0, drsp.quotient} - 1'b1;
                    i_next     = '0;
                    state_next = S_FKEY;
                    dreq       = '{start: 1'b1, dividend: n_reg, divisor: NW'(1)};
                end
            end
            // fill: entry i gets key(i) - 1
            S_FKEY:
            begin
                if ({1'b0, i_reg} >= len_reg)
                begin
                    p_next     = NW'(2);
                    state_next = S_PRD1;
                end
                else if (i_reg >= r_reg)
                begin
                    keyv       = len_reg - {1'b0, i_reg};
                    we         = 1'b1;
                    waddr      = i_reg[AW-1:0];
                    wdata      = CW'(keyv) - 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                else if (drsp.done)
                begin
                    we         = 1'b1;
                    waddr      = i_reg[AW-1:0];
                    wdata      = CW'(drsp.quotient) - 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_FWR;
                end
            end
            S_FWR:
            begin
                if (i_reg < r_reg)
                begin
                    dreq = '{start: 1'b1, dividend: n_reg, divisor: i_reg + 1'b1};
                end
                state_next = S_FKEY;
            end
            // prime test: read S(p-1) then S(p); all p <= r are tail slots
            S_PRD1:
            begin
                if (p_reg > r_reg)
                begin
                    pd_next    = '{prime_count: '0, count_valid: 1'b1};
                    built_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr      = tail_slot(len_reg, p_reg - 1'b1);
                    state_next = S_PRD2;
                end
            end
            S_PRD2:
            begin
                below_next = rdata;
                raddr      = tail_slot(len_reg, p_reg);
                state_next = S_PCHK;
                sub_next   = 4'd0;
            end
            S_PCHK:
            begin
                if (rdata <= below_reg)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_PRD1;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_UKEY;
                    if (r_reg != '0)
                    begin
                        dreq = '{start: 1'b1, dividend: n_reg,
                                 divisor: NW'(1)};
                    end
                end
            end
            // update walk: key(i) in head comes from divider
            S_UKEY:
            begin
                if ({1'b0, i_reg} >= len_reg)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_PRD1;
                end
                else if (i_reg >= r_reg)
                begin
                    keyv = len_reg - {1'b0, i_reg};
                    if ((2*NW)'(keyv) < psq)
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_PRD1;
                    end
                    else
                    begin
                        v_next     = keyv[NW-1:0];
                        dreq       = '{start: 1'b1, dividend: keyv[NW-1:0],
                                       divisor: p_reg};
                        state_next = S_UDIV;
                    end
                end
                else if (drsp.done)
                begin
                    if ((2*NW)'(drsp.quotient) < psq)
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_PRD1;
                    end
                    else
                    begin
                        v_next     = drsp.quotient;
                        dreq       = '{start: 1'b1, dividend: drsp.quotient,
                                       divisor: p_reg};
                        state_next = S_UDIV;
                    end
                end
            end
            S_UDIV:
            begin
                if (drsp.done)
                begin
                    q_next     = drsp.quotient;
                    state_next = S_SLOT;
                end
            end
            // w = v/p; its slot: tail if w <= n/r, else n/w - 1
            S_SLOT:
            begin
                if (q_reg <= top_reg)
                begin
                    raddr      = tail_slot(len_reg, q_reg);
                    state_next = S_URD1;
                end
                else if (sub_reg != 4'd2)
                begin
                    dreq     = '{start: 1'b1, dividend: n_reg, divisor: q_reg};
                    sub_next = 4'd2;
                end
                else if (drsp.done)
                begin
                    raddr      = head_slot(drsp.quotient);
                    state_next = S_URD1;
                    sub_next   = 4'd0;
                end
            end
            S_URD1:
            begin
                cur_next   = rdata;
                raddr      = i_reg[AW-1:0];
                state_next = S_URD2;
            end
            // hold the address so S(key) is on rdata in the write cycle
            S_URD2:
            begin
                raddr      = i_reg[AW-1:0];
                state_next = S_UWR;
            end
            S_UWR:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = rdata - (cur_reg - below_reg);
                i_next     = i_reg + 1'b1;
                state_next = S_UKEY;
                if (i_reg + 1'b1 < r_reg)
                begin
                    dreq = '{start: 1'b1, dividend: n_reg, divisor: i_reg + NW'(2)};
                end
            end
            // query: q = n/v, key test n/q == v
            S_QDIV1:
            begin
                if (drsp.done)
                begin
                    q_next = drsp.quotient;
                    if (v_reg <= top_reg)
                    begin
                        raddr      = tail_slot(len_reg, v_reg);
                        state_next = S_QRD;
                    end
                    else
                    begin
                        dreq       = '{start: 1'b1, dividend: n_reg,
                                       divisor: drsp.quotient};
                        state_next = S_QDIV2;
                    end
                end
            end
            S_QDIV2:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient != v_reg)
                    begin
                        pd_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr      = head_slot(q_reg);
                        state_next = S_QRD;
                    end
                end
            end
            S_QRD:
            begin
                pd_next    = '{prime_count: rdata[NW-1:0], count_valid: 1'b1};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                pend_next  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register
        if (pend_reg && out_free)
        begin
            pend_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        if (out_valid && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (pend_reg && out_free)
        begin
            ov_next = 1'b1;
            od_next = pd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            built_reg <= 1'b0;
            len_reg   <= '0;
            r_reg     <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            built_reg <= built_next;
            len_reg   <= len_next;
            r_reg     <= r_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        below_reg  <= below_next;
        cur_reg    <= cur_next;
        v_reg      <= v_next;
        q_reg      <= q_next;
        sq_rem_reg <= sq_rem_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        od_reg     <= od_next;
        pd_reg     <= pd_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

[hdl/lpct_ram.sv]
module lpct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lpct_div.sv]
module lpct_div
    import lpct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpct_div_req_t req,
    output lpct_div_rsp_t rsp
);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW:0]   trial;
    logic [NW:0]   shifted;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[NW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 5'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[NW])
            begin
                rem_next = trial[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hdl/lpct_checker.sv]
module lpct_checker
    import lpct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  lpct_out_t out_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an invalid result carries no count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.count_valid |-> out_data.prime_count == '0)
        else $error("count without valid flag");

    // an accepted beat blocks input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken at once");

    // a result only follows a cycle in which the input was blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while idle");

endmodule

bind lucy_prime_count_table_unit lpct_checker u_lpct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
